FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds on every clock edge outside reset.
`define U8_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define U8_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define U8_ASSERT(lbl, clk, rst_n, prop, msg)
`define U8_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/u8enc_pkg.sv
package u8enc_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [20:0] MAX_ONE     = 21'h00007F;
    localparam logic [20:0] MAX_TWO     = 21'h0007FF;
    localparam logic [20:0] MAX_THREE   = 21'h00FFFF;
    localparam logic [7:0]  LEAD_TWO    = 8'hC0;
    localparam logic [7:0]  LEAD_THREE  = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR   = 8'hF0;
    localparam logic [7:0]  CONT_MARK   = 8'h80;

    localparam logic MODE_UTF16 = 1'b0;
    localparam logic MODE_UTF32 = 1'b1;

    // One queued job: an optional lone held surrogate, then an optional code point.
    typedef struct packed {
        logic        pre_valid;
        logic [15:0] pre_cp;
        logic        main_valid;
        logic [20:0] main_cp;
        logic        last;
    } t_job;

    typedef struct packed {
        logic held_valid;
        logic mode;
    } t_front_status;

    typedef enum logic {
        SEG_PRE,
        SEG_MAIN
    } t_seg_phase;

    // Index of the final byte of a code point's UTF-8 form (length minus one).
    function automatic logic [1:0] last_idx(input logic [20:0] cp);
        logic [1:0] r;
        if (cp <= MAX_ONE) begin
            r = 2'd0;
        end else if (cp <= MAX_TWO) begin
            r = 2'd1;
        end else if (cp <= MAX_THREE) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

    // Byte number idx (0 = lead byte) of a code point's UTF-8 form.
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
        logic [1:0] n;
        logic [1:0] pos;
        logic [7:0] b;
        n   = last_idx(cp);
        pos = n - idx;
        if (idx == 2'd0) begin
            unique case (n)
                2'd0:    b = {1'b0, cp[6:0]};
                2'd1:    b = LEAD_TWO   | {3'b000, cp[10:6]};
                2'd2:    b = LEAD_THREE | {4'b0000, cp[15:12]};
                default: b = LEAD_FOUR  | {5'b00000, cp[20:18]};
            endcase
        end else begin
            unique case (pos)
                2'd0:    b = CONT_MARK | {2'b00, cp[5:0]};
                2'd1:    b = CONT_MARK | {2'b00, cp[11:6]};
                default: b = CONT_MARK | {2'b00, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

FILE: rtl/u8enc_queue.sv
module u8enc_queue #(
    parameter int unsigned DEPTH = u8enc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  u8enc_pkg::t_job  i_wr_data,
    output logic             o_full,
    input  logic             i_rd_en,
    output u8enc_pkg::t_job  o_rd_data,
    output logic             o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    u8enc_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;

    logic do_wr, do_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr_en && !o_full;
    assign do_rd   = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: rtl/u8enc_front.sv
module u8enc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_data,
    input  logic                      i_accept,
    input  logic [20:0]               i_code_unit,
    input  logic                      i_last_unit,
    output u8enc_pkg::t_job           o_job,
    output logic                      o_job_valid,
    output u8enc_pkg::t_front_status  o_status
);

    logic        r_mode;
    logic        r_held_valid, n_held_valid;
    logic [15:0] r_held,       n_held;

    logic [15:0] unit16;
    logic        is_hi, is_lo;
    u8enc_pkg::t_job job;

    assign unit16 = i_code_unit[15:0];
    assign is_hi  = (unit16 >= u8enc_pkg::HI_SURR_MIN) && (unit16 <= u8enc_pkg::HI_SURR_MAX);
    assign is_lo  = (unit16 >= u8enc_pkg::LO_SURR_MIN) && (unit16 <= u8enc_pkg::LO_SURR_MAX);

    // Classify the unit: pair, lone held surrogate, hold, or plain code point.
    always_comb begin
        job          = '0;
        job.last     = i_last_unit;
        n_held_valid = r_held_valid;
        n_held       = r_held;
        if (r_mode == u8enc_pkg::MODE_UTF32) begin
            job.main_valid = 1'b1;
            job.main_cp    = i_code_unit;
        end else if (r_held_valid && is_lo) begin
            job.main_valid = 1'b1;
            job.main_cp    = u8enc_pkg::SUPP_BASE + {1'b0, r_held[9:0], unit16[9:0]};
            n_held_valid   = 1'b0;
        end else begin
            job.pre_valid = r_held_valid;
            job.pre_cp    = r_held;
            n_held_valid  = 1'b0;
            if (is_hi && !i_last_unit) begin
                n_held_valid = 1'b1;
                n_held       = unit16;
            end else begin
                job.main_valid = 1'b1;
                job.main_cp    = {5'b00000, unit16};
            end
        end
    end

    assign o_job       = job;
    assign o_job_valid = job.pre_valid || job.main_valid;
    assign o_status    = '{held_valid: r_held_valid, mode: r_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= u8enc_pkg::MODE_UTF16;
            r_held_valid <= 1'b0;
        end else if (i_cfg_valid) begin
            // Drop any held surrogate on a mode write.
            r_mode       <= i_cfg_data;
            r_held_valid <= 1'b0;
        end else if (i_accept) begin
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

FILE: rtl/u8enc_back.sv
module u8enc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u8enc_pkg::t_job  i_job,
    input  logic             i_job_valid,
    output logic             o_job_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_string_last
);

    u8enc_pkg::t_seg_phase r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_run_last;
    logic        r_string_last;

    logic        eff_main;
    logic [20:0] cur_cp;
    logic        seg_last;
    logic        job_done;
    logic        advance;
    logic [7:0]  cur_byte;

    assign advance = i_job_valid && (!r_out_valid || i_pop);

    // Output logic: pick the segment and byte in flight.
    always_comb begin
        eff_main = (r_phase == u8enc_pkg::SEG_MAIN) || !i_job.pre_valid;
        cur_cp   = eff_main ? i_job.main_cp : {5'b00000, i_job.pre_cp};
        seg_last = (r_idx == u8enc_pkg::last_idx(cur_cp));
        job_done = seg_last && (eff_main || !i_job.main_valid);
        cur_byte = u8enc_pkg::utf8_byte(cur_cp, r_idx);
    end

    // Next state: step through bytes, then segments, then release the job.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (advance) begin
            if (!seg_last) begin
                n_idx = r_idx + 1'b1;
            end else begin
                n_idx   = 2'd0;
                n_phase = job_done ? u8enc_pkg::SEG_PRE : u8enc_pkg::SEG_MAIN;
            end
        end
    end

    assign o_job_pop = advance && job_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= u8enc_pkg::SEG_PRE;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte    <= cur_byte;
            r_run_last    <= job_done;
            r_string_last <= job_done && i_job.last;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_run_last;
    assign o_string_last = r_string_last;

endmodule

FILE: rtl/utf16_utf32_to_utf8_encoder.sv
// An item's first byte passes through the job queue, then the output register.
// Throughput: one UTF-8 byte per cycle while the reader pops; an item yields 1 to 6 bytes
// through the single byte-wide output register; a unit that is only held yields none.
// The front accepts a unit per cycle while the job queue (QUEUE_DEPTH jobs) has room.
// Reset (i_rst_n low at a clock edge, synchronous) empties the queue and the output,
// drops any held surrogate and selects UTF-16 mode.
`include "assert_macros.svh"

module utf16_utf32_to_utf8_encoder #(
    parameter int unsigned QUEUE_DEPTH = u8enc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel (mode register)
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [20:0] i_code_unit,
    input  logic        i_last_unit,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_string_last
);

    u8enc_pkg::t_job           front_job;
    logic                      front_job_valid;
    u8enc_pkg::t_front_status  front_status;
    u8enc_pkg::t_job           q_rd_data;
    logic                      q_full;
    logic                      q_empty;
    logic                      q_wr_en;
    logic                      q_rd_en;
    logic                      in_accept;
    logic                      cfg_write;

    // The user must send mode writes only while idle; the block does not enforce this and takes them at once.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // Accept a transaction whenever the job queue has room; hold-only units push nothing.
    assign full      = q_full;
    assign in_accept = push && !q_full;
    assign q_wr_en   = in_accept && front_job_valid;

    // Front: track the held high surrogate and turn each unit into a job.
    u8enc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_write),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_code_unit (i_code_unit),
        .i_last_unit (i_last_unit),
        .o_job       (front_job),
        .o_job_valid (front_job_valid),
        .o_status    (front_status)
    );

    // Job queue decouples classification from byte emission.
    u8enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_wr_en),
        .i_wr_data (front_job),
        .o_full    (q_full),
        .i_rd_en   (q_rd_en),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    // Back: expand the head job to UTF-8 bytes via the output register, one per cycle when popped.
    u8enc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (q_rd_data),
        .i_job_valid   (!q_empty),
        .o_job_pop     (q_rd_en),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_string_last (o_string_last)
    );

    // A surrogate is only ever held in UTF-16 mode.
    `U8_ASSERT_NEVER(a_held_only_utf16, i_clk, i_rst_n, front_status.held_valid && (front_status.mode == u8enc_pkg::MODE_UTF32), "surrogate held in UTF-32 mode")
    // The back never releases a job the queue does not have.
    `U8_ASSERT_NEVER(a_no_pop_when_empty, i_clk, i_rst_n, q_rd_en && q_empty, "job released from empty queue")
    // The end of a string is always the end of an item's bytes.
    `U8_ASSERT(a_string_last_ends_run, i_clk, i_rst_n, (!empty && o_string_last) |-> o_run_last, "string end without run end")
    // A job is never written into the queue while it is full.
    `U8_ASSERT_NEVER(a_no_queue_overflow, i_clk, i_rst_n, q_wr_en && q_full, "job written to full queue")

endmodule
